FILE: sv/hoc_pkg.sv
`default_nettype none

package hoc_pkg;

   localparam int WORD_W          = 63;
   localparam int SYN_W           = 6;
   localparam int R_W             = 3;
   localparam int MIN_PARITY_BITS = 2;
   localparam int MAX_PARITY_BITS = 6;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   // register index taken from the word address
   localparam logic REG_PARITY_BITS = 1'b0;
   localparam logic [R_W-1:0] PARITY_BITS_RESET = R_W'(3);

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   // after the front stage: codeword body (parity slots empty on encode)
   typedef struct packed {
      cmd_type           cmd;
      logic [R_W-1:0]    r;
      logic [WORD_W-1:0] body;
   } front_type;

   // after the check stage: per-group result, 1 = group holds an even count
   typedef struct packed {
      cmd_type           cmd;
      logic [SYN_W-1:0]  fails;
      logic [WORD_W-1:0] body;
   } check_type;

   // data bit i goes to the i-th position that is not a power of two
   function automatic logic [WORD_W-1:0] scatter_data(input logic [WORD_W-1:0] data);
      logic [WORD_W-1:0] code;
      int di;
      code = '0;
      di   = 0;
      for (int p = 1; p <= WORD_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            code[p-1] = data[di];
            di++;
         end
      end
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] gather_data(input logic [WORD_W-1:0] code);
      logic [WORD_W-1:0] data;
      int di;
      data = '0;
      di   = 0;
      for (int p = 1; p <= WORD_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            data[di] = code[p-1];
            di++;
         end
      end
      return data;
   endfunction

   // positions 1 .. 2^r-1
   function automatic logic [WORD_W-1:0] len_mask(input logic [R_W-1:0] r);
      logic [WORD_W-1:0] m;
      for (int p = 0; p < WORD_W; p++) begin
         m[p] = ((p + 1) < (1 << r));
      end
      return m;
   endfunction

   // positions with bit k set
   function automatic logic [WORD_W-1:0] group_mask(input int k);
      logic [WORD_W-1:0] m;
      for (int p = 0; p < WORD_W; p++) begin
         m[p] = (((p + 1) >> k) & 1) != 0;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: sv/hoc_front.sv
`default_nettype none

module hoc_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic                       in_cmd,
   input  wire logic [hoc_pkg::WORD_W-1:0] in_word,
   input  wire logic [hoc_pkg::R_W-1:0]    r_raw,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output hoc_pkg::front_type              out_item
);
   import hoc_pkg::*;

   logic              valid_ff;
   front_type         item_ff;
   front_type         item_in;
   logic [R_W-1:0]    r_eff;
   logic [WORD_W-1:0] nmask;

   always_comb begin
      if (r_raw < R_W'(MIN_PARITY_BITS)) begin
         r_eff = R_W'(MIN_PARITY_BITS);
      end else if (r_raw > R_W'(MAX_PARITY_BITS)) begin
         r_eff = R_W'(MAX_PARITY_BITS);
      end else begin
         r_eff = r_raw;
      end
      nmask        = len_mask(r_eff);
      item_in.cmd  = cmd_type'(in_cmd);
      item_in.r    = r_eff;
      if (cmd_type'(in_cmd) == CMD_ENCODE) begin
         item_in.body = scatter_data(in_word) & nmask;
      end else begin
         item_in.body = in_word & nmask;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hoc_check.sv
`default_nettype none

module hoc_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire hoc_pkg::front_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output hoc_pkg::check_type      out_item
);
   import hoc_pkg::*;

   logic      valid_ff;
   check_type item_ff;
   check_type item_in;

   // a group with an even count fails its odd-parity check
   always_comb begin
      item_in.cmd  = in_item.cmd;
      item_in.body = in_item.body;
      for (int k = 0; k < SYN_W; k++) begin
         item_in.fails[k] = !(^(in_item.body & group_mask(k)))
                            && (R_W'(k) < in_item.r);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hoc_back.sv
`default_nettype none

module hoc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire hoc_pkg::check_type          in_item,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [hoc_pkg::WORD_W-1:0]       out_word,
   output logic                             out_failed,
   output logic [hoc_pkg::SYN_W-1:0]        out_syndrome
);
   import hoc_pkg::*;

   logic              valid_ff;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic              failed_ff;
   logic              failed_in;
   logic [SYN_W-1:0]  syn_ff;
   logic [SYN_W-1:0]  syn_in;
   logic [WORD_W-1:0] par_bits;

   always_comb begin
      par_bits = '0;
      for (int k = 0; k < SYN_W; k++) begin
         par_bits[(1 << k) - 1] = in_item.fails[k];
      end
      word_in   = '0;
      failed_in = 1'b0;
      syn_in    = '0;
      case (in_item.cmd)
         CMD_ENCODE: begin
            word_in = in_item.body | par_bits;
         end
         CMD_DECODE: begin
            if (in_item.fails != '0) begin
               failed_in = 1'b1;
               syn_in    = in_item.fails;
            end else begin
               word_in = gather_data(in_item.body);
            end
         end
         default: begin
            word_in = '0;
         end
      endcase
   end

   assign in_ready     = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign out_word     = word_ff;
   assign out_failed   = failed_ff;
   assign out_syndrome = syn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff   <= word_in;
         failed_ff <= failed_in;
         syn_ff    <= syn_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hamming_odd_parity_codec.sv
// Odd-parity Hamming codec, full-length code, detect only. parity_bits (r,
// clamped to 2..6) sets a codeword of 2^r-1 bits with 2^r-1-r data bits;
// codeword bit 0 is position 1. cmd 0 encodes right-aligned data, cmd 1
// checks a codeword and returns the packed data, or zero with check_failed
// and the syndrome (failing position) when any check fails. Takes one word
// per clock unless back-pressure stalls it; three register stages: data
// scatter and length masking, the six group-parity XOR trees, and codeword
// or data assembly into the output register. Every stage carries its own
// valid and stalls only when full and blocked downstream, so back-pressure
// on rsp_ loses no transfer. Write parity_bits only when the pipe is empty.
`default_nettype none

module hamming_odd_parity_codec (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cmd,
   input  wire logic [hoc_pkg::WORD_W-1:0]     req_word_in,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [hoc_pkg::WORD_W-1:0]          rsp_word_out,
   output logic                                rsp_check_failed,
   output logic [hoc_pkg::SYN_W-1:0]           rsp_syndrome,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hoc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [hoc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hoc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import hoc_pkg::*;

   logic [R_W-1:0] parity_bits_ff;
   logic           csr_hit;

   logic      front_valid;
   logic      front_ready;
   front_type front_item;
   logic      check_valid;
   logic      check_ready;
   check_type check_item;

   // word address bit selects the register; byte offset bits are ignored
   assign csr_hit = (paddr[CSR_ADDR_W-1] == REG_PARITY_BITS);
   assign pready  = 1'b1;

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = CSR_DATA_W'(parity_bits_ff);
      end
   end

   // raw count is stored; clamping happens per transfer in the front stage
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_bits_ff <= PARITY_BITS_RESET;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         parity_bits_ff <= pwdata[R_W-1:0];
      end
   end

   hoc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (req_cmd),
      .in_word   (req_word_in),
      .r_raw     (parity_bits_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   hoc_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (check_valid),
      .out_ready (check_ready),
      .out_item  (check_item)
   );

   hoc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (check_valid),
      .in_ready     (check_ready),
      .in_item      (check_item),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_word     (rsp_word_out),
      .out_failed   (rsp_check_failed),
      .out_syndrome (rsp_syndrome)
   );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the odd-parity Hamming codec.
// Flow: reset, a directed table (field extremes, both commands, clamped
// parity counts, excess input bits, single and all-group check failures),
// then random phases, one per parity_bits setting. Between phases the pipe is
// drained before parity_bits is rewritten and read back.
// Every accepted request queues one expected response; the response monitor
// pops and compares each field as responses transfer.
module tb_top;
   import hoc_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_ITEMS     = 44;
   localparam int DRAIN_SLACK     = 6;    // pipe is three stages deep
   localparam int HOLD_AFTER      = 80;   // accepted requests before the long stall
   localparam int HOLD_CYCLES     = 64;
   localparam logic [CSR_ADDR_W-1:0] PARITY_BITS_ADDR = CSR_ADDR_W'(4 * REG_PARITY_BITS);
   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              failed;
      logic [SYN_W-1:0]  syn;
   } codec_result_type;

   // Directed probe; typed = 1 means the expected response is given in the row.
   typedef struct {
      logic [R_W-1:0]    r_cfg;
      cmd_type           cmd;
      logic [WORD_W-1:0] word;
      bit                typed;
      logic [WORD_W-1:0] want_word;
      logic              want_failed;
      logic [SYN_W-1:0]  want_syn;
   } probe_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   cmd_type               req_cmd;
   logic [WORD_W-1:0]     req_word_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [WORD_W-1:0]     rsp_word_out;
   logic                  rsp_check_failed;
   logic [SYN_W-1:0]      rsp_syndrome;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   codec_result_type      codec_results_due[$];
   logic [R_W-1:0]        parity_setting;
   int                    mismatch_count = 0;
   int                    items_accepted = 0;
   int                    burst_left     = 0;
   int                    cycle_count    = 0;

   // Reset state is r = 3 (7-bit code). Codes hand-worked from the spec:
   //  r=3: zero data -> parity at positions 1,2,4; all-ones data -> 0x74
   //  r=2: data 1 -> 0b100; r=6: zero data -> parity at 1,2,4,8,16,32
   probe_row_type probe_rows [26] = '{
      '{3'd3, CMD_ENCODE, 63'h0,                 1'b1, 63'h0B,                 1'b0, 6'd0},
      '{3'd3, CMD_ENCODE, ALL_ONES,              1'b1, 63'h74,                 1'b0, 6'd0},
      '{3'd3, CMD_DECODE, 63'h0,                 1'b1, 63'h0,                  1'b1, 6'd7},
      '{3'd3, CMD_DECODE, ALL_ONES,              1'b1, 63'h0,                  1'b1, 6'd7},
      '{3'd3, CMD_DECODE, 63'h0B,                1'b1, 63'h0,                  1'b0, 6'd0},
      '{3'd3, CMD_DECODE, 63'h74,                1'b1, 63'hF,                  1'b0, 6'd0},
      // position 5 flipped: groups 0 and 2 go even
      '{3'd3, CMD_DECODE, 63'h1B,                1'b1, 63'h0,                  1'b1, 6'd5},
      // junk above the codeword length is ignored
      '{3'd3, CMD_DECODE, 63'h7FFF_FFFF_FFFF_FF74, 1'b1, 63'hF,                1'b0, 6'd0},
      '{3'd3, CMD_ENCODE, 63'h7FFF_FFFF_FFFF_FFF0, 1'b1, 63'h0B,               1'b0, 6'd0},
      '{3'd3, CMD_ENCODE, 63'h5,                 1'b0, 63'h0,                  1'b0, 6'd0},
      '{3'd2, CMD_ENCODE, 63'h0,                 1'b1, 63'h3,                  1'b0, 6'd0},
      '{3'd2, CMD_ENCODE, 63'h1,                 1'b1, 63'h4,                  1'b0, 6'd0},
      '{3'd2, CMD_DECODE, 63'h7,                 1'b1, 63'h0,                  1'b1, 6'd3},
      '{3'd2, CMD_DECODE, 63'h4,                 1'b1, 63'h1,                  1'b0, 6'd0},
      '{3'd2, CMD_DECODE, 63'h5,                 1'b1, 63'h0,                  1'b1, 6'd1},
      '{3'd6, CMD_ENCODE, 63'h0,                 1'b1, 63'h8000_808B,          1'b0, 6'd0},
      '{3'd6, CMD_ENCODE, ALL_ONES,              1'b1, 63'h7FFF_FFFF_7FFF_7F74, 1'b0, 6'd0},
      '{3'd6, CMD_DECODE, ALL_ONES,              1'b1, 63'h0,                  1'b1, 6'd63},
      '{3'd6, CMD_DECODE, 63'h7FFF_FFFF_7FFF_7F74, 1'b1, 63'h1FF_FFFF_FFFF_FFFF, 1'b0, 6'd0},
      // top position flipped: it sits in every group
      '{3'd6, CMD_DECODE, 63'h3FFF_FFFF_7FFF_7F74, 1'b1, 63'h0,                1'b1, 6'd63},
      '{3'd6, CMD_DECODE, 63'h0,                 1'b1, 63'h0,                  1'b1, 6'd63},
      '{3'd6, CMD_ENCODE, 63'h5555_5555_5555_5555, 1'b0, 63'h0,                1'b0, 6'd0},
      // counts below 2 act as 2, above 6 act as 6
      '{3'd0, CMD_ENCODE, 63'h0,                 1'b1, 63'h3,                  1'b0, 6'd0},
      '{3'd0, CMD_DECODE, 63'h7,                 1'b1, 63'h0,                  1'b1, 6'd3},
      '{3'd7, CMD_DECODE, ALL_ONES,              1'b1, 63'h0,                  1'b1, 6'd63},
      '{3'd1, CMD_ENCODE, 63'h1,                 1'b1, 63'h4,                  1'b0, 6'd0}
   };

   hamming_odd_parity_codec u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_word_in      (req_word_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_out     (rsp_word_out),
      .rsp_check_failed (rsp_check_failed),
      .rsp_syndrome     (rsp_syndrome),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // parity_bits clamped into 2..6
   function automatic int unsigned used_parity_bits(input logic [R_W-1:0] cfg);
      if (cfg < MIN_PARITY_BITS) return MIN_PARITY_BITS;
      if (cfg > MAX_PARITY_BITS) return MAX_PARITY_BITS;
      return cfg;
   endfunction

   // Encode: scatter data over non-power-of-two positions, then set each
   // parity bit that would leave its group even. Decode: a group with an even
   // count sets its syndrome bit; a clean word gets its data gathered.
   function automatic codec_result_type codec_predict(input cmd_type c,
                                                      input logic [WORD_W-1:0] w,
                                                      input logic [R_W-1:0] cfg);
      int unsigned       r;
      int unsigned       code_len;
      int unsigned       di;
      logic [WORD_W-1:0] code;
      logic [WORD_W-1:0] data;
      logic [SYN_W-1:0]  syn;
      logic              par;
      codec_result_type  res;
      r        = used_parity_bits(cfg);
      code_len = (1 << r) - 1;
      code     = '0;
      data     = '0;
      syn      = '0;
      di       = 0;
      res      = '0;
      if (c == CMD_ENCODE) begin
         for (int p = 1; p <= code_len; p++) begin
            if ((p & (p - 1)) != 0) begin
               code[p-1] = w[di];
               di++;
            end
         end
         for (int k = 0; k < r; k++) begin
            par = 1'b0;
            for (int p = 1; p <= code_len; p++)
               if (((p >> k) & 1) != 0) par ^= code[p-1];
            if (!par) code[(1 << k) - 1] = 1'b1;
         end
         res.word = code;
      end else begin
         for (int k = 0; k < r; k++) begin
            par = 1'b0;
            for (int p = 1; p <= code_len; p++)
               if (((p >> k) & 1) != 0) par ^= w[p-1];
            if (!par) syn[k] = 1'b1;
         end
         if (syn != '0) begin
            res.failed = 1'b1;
            res.syn    = syn;
         end else begin
            for (int p = 1; p <= code_len; p++) begin
               if ((p & (p - 1)) != 0) begin
                  data[di] = w[p-1];
                  di++;
               end
            end
            res.word = data;
         end
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[WORD_W-1:0];
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Called and returns at a falling edge. Valid stays up across a burst;
   // between bursts it drops for a random gap with junk on the payload.
   task automatic offer_item(input cmd_type c, input logic [WORD_W-1:0] w,
                             input codec_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         repeat (gap) begin
            req_valid   = 1'b0;
            req_cmd     = cmd_type'($urandom_range(0, 1));
            req_word_in = rand_word();
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid   = 1'b1;
      req_cmd     = c;
      req_word_in = w;
      do @(posedge clock); while (!req_ready);
      codec_results_due.push_back(want);
      items_accepted++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = addr;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic check_parity_readback(input logic [R_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_read(PARITY_BITS_ADDR, readback);
      if (readback[R_W-1:0] !== value)
         flag_mismatch($sformatf("parity_bits readback expected %0d got %0d",
                                 value, readback[R_W-1:0]));
   endtask

   // Only touch the register with the pipe empty.
   task automatic set_parity(input logic [R_W-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      req_valid = 1'b0;
      while (codec_results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
      wdata          = $urandom;    // upper bits are don't-care
      wdata[R_W-1:0] = value;
      csr_write(PARITY_BITS_ADDR, wdata);
      check_parity_readback(value);
      parity_setting = value;
   endtask

   // Response checker: every transfer must match the oldest expectation.
   always @(posedge clock) begin
      codec_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (codec_results_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer word_out=%h check_failed=%b syndrome=%0d",
                                    rsp_word_out, rsp_check_failed, rsp_syndrome));
         end else begin
            want = codec_results_due.pop_front();
            if (rsp_word_out !== want.word || rsp_check_failed !== want.failed ||
                rsp_syndrome !== want.syn)
               flag_mismatch($sformatf({"expected word_out=%h check_failed=%b syndrome=%0d, ",
                                        "got word_out=%h check_failed=%b syndrome=%0d"},
                                       want.word, want.failed, want.syn,
                                       rsp_word_out, rsp_check_failed, rsp_syndrome));
         end
      end
   end

   // Receiver: random stall modes, plus one long hold-off once traffic is
   // flowing so the pipe fills and req_ready drops.
   initial begin
      int  mode;
      int  mode_left;
      int  hold_left;
      bit  hold_done;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(4, 40);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_ready = 1'b1;
               end
               1: begin
                  rsp_ready = ($urandom_range(0, 1) == 1);
               end
               2: begin
                  rsp_ready = ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ready = ($urandom_range(0, 4) != 0);
               end
            endcase
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hamming_odd_parity_codec verification failed");
         $finish;
      end
   end

   initial begin
      logic [R_W-1:0]    phase_settings [9];
      codec_result_type  want;
      cmd_type           c;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] data;
      int unsigned       code_len;
      int                sel;
      int                flips;
      int                failures;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_ENCODE;
      req_word_in    = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      parity_setting = PARITY_BITS_RESET;
      phase_settings = '{3'd4, 3'd5, 3'd2, 3'd6, 3'd0, 3'd7, 3'd1, 3'd3, 3'd0};
      phase_settings[8] = R_W'($urandom_range(0, 7));

      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      check_parity_readback(PARITY_BITS_RESET);

      // directed table
      foreach (probe_rows[i]) begin
         if (probe_rows[i].r_cfg != parity_setting) set_parity(probe_rows[i].r_cfg);
         if (probe_rows[i].typed)
            want = '{probe_rows[i].want_word, probe_rows[i].want_failed,
                     probe_rows[i].want_syn};
         else
            want = codec_predict(probe_rows[i].cmd, probe_rows[i].word, parity_setting);
         offer_item(probe_rows[i].cmd, probe_rows[i].word, want);
      end

      // Random phases. Mix: raw encodes, decodes of real codewords (mostly
      // clean, some with one or two flipped bits, some with junk above the
      // code length), and pure-noise decodes.
      foreach (phase_settings[i]) begin
         set_parity(phase_settings[i]);
         code_len = (1 << used_parity_bits(parity_setting)) - 1;
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            sel  = $urandom_range(0, 9);
            data = rand_word();
            if (sel < 4) begin
               c = CMD_ENCODE;
               w = (sel == 0) ? (data & rand_word()) : data;
            end else if (sel < 8) begin
               c     = CMD_DECODE;
               want  = codec_predict(CMD_ENCODE, data, parity_setting);
               w     = want.word;
               flips = $urandom_range(0, 4);
               if (flips > 2) flips = 0;
               repeat (flips) w[$urandom_range(0, code_len - 1)] ^= 1'b1;
               if ($urandom_range(0, 3) == 0) w = w | (rand_word() << code_len);
            end else begin
               c = CMD_DECODE;
               w = data;
            end
            offer_item(c, w, codec_predict(c, w, parity_setting));
         end
      end

      req_valid = 1'b0;
      while (codec_results_due.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      failures = mismatch_count + codec_results_due.size();
      if (failures == 0) begin
         $display("hamming_odd_parity_codec verification clean");
      end else begin
         $display("hamming_odd_parity_codec verification failed");
      end
      $finish;
   end

endmodule
